/* design/mvt_pkg.sv */
// Shared types and constants for the 4x4 matrix-vector transform unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package mvt_pkg;

  localparam int ELEM_W  = 32;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int VEC_LEN = 4;
  localparam int IDX_W   = 2;

  // s_tdata layout, lowest bit first: row, column, element_value, vec_x..vec_w
  localparam int ROW_LSB  = 0;
  localparam int COL_LSB  = ROW_LSB + IDX_W;
  localparam int ELEM_LSB = COL_LSB + IDX_W;
  localparam int VEC_LSB  = ELEM_LSB + ELEM_W;
  localparam int IN_BITS  = VEC_LSB + VEC_LEN * ELEM_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = VEC_LEN * ELEM_W;

  // operation codes carried in s_tuser
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  typedef logic signed [ELEM_W-1:0] q16_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // load enables for the three pipeline stages after the input register
  typedef struct packed {
    logic en_mul;
    logic en_pair;
    logic en_out;
  } stage_ctl_t;

endpackage

`default_nettype wire

/* design/mvt_matrix.sv */
// Matrix element store: DIM x DIM Q16.16 registers, cleared on reset.
// Depends on mvt_pkg.
`default_nettype none

module mvt_matrix
  import mvt_pkg::*;
#(
  parameter int DIM = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_row,
  input  wire logic [IDX_W-1:0] wr_col,
  input  wire q16_t             wr_data,
  output q16_t                  elem [DIM][DIM]
);

  // each element has its own decode; writes outside DIM match nothing
  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (rst) begin
          elem[r][c] <= '0;
        end else if (wr_en && wr_row == IDX_W'(r) && wr_col == IDX_W'(c)) begin
          elem[r][c] <= wr_data;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/mvt_row.sv */
// One row's dot product: registered products, registered pair sums,
// then final add, floor shift by FRAC_BITS and 32-bit clamp into the result register.
// Depends on mvt_pkg.
`default_nettype none

module mvt_row
  import mvt_pkg::*;
#(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic       clk,
  input  wire stage_ctl_t ctl,
  input  wire q16_t       coef [DIM],
  input  wire q16_t       vec [VEC_LEN],
  output q16_t            result,
  output logic            sat
);

  localparam int PAIRS  = (DIM + 1) / 2;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PAIR_W + 1;
  localparam logic signed [SUM_W-1:0] HI = SUM_W'($signed(32'h7FFF_FFFF));
  localparam logic signed [SUM_W-1:0] LO = SUM_W'($signed(32'h8000_0000));

  prod_t                    prod [DIM];
  logic signed [PAIR_W-1:0] psum [PAIRS];
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  shifted;

  for (genvar c = 0; c < DIM; c++) begin : g_mul
    always_ff @(posedge clk) begin
      if (ctl.en_mul) begin
        prod[c] <= coef[c] * vec[c];
      end
    end
  end

  for (genvar p = 0; p < PAIRS; p++) begin : g_pair
    if (2 * p + 1 < DIM) begin : g_two
      always_ff @(posedge clk) begin
        if (ctl.en_pair) begin
          psum[p] <= PAIR_W'(prod[2*p]) + PAIR_W'(prod[2*p+1]);
        end
      end
    end else begin : g_one
      always_ff @(posedge clk) begin
        if (ctl.en_pair) begin
          psum[p] <= PAIR_W'(prod[2*p]);
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int p = 0; p < PAIRS; p++) begin
      total = total + SUM_W'(psum[p]);
    end
    // arithmetic shift floors toward minus infinity
    shifted = total >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      priority if (shifted > HI) begin
        result <= q16_t'(HI);
        sat    <= 1'b1;
      end else if (shifted < LO) begin
        result <= q16_t'(LO);
        sat    <= 1'b1;
      end else begin
        result <= shifted[ELEM_W-1:0];
        sat    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/matrix4_vector_transform.sv */
// Top level of the 4x4 matrix-vector transform unit: stream ports, input register,
// stage valids and row units. Depends on mvt_pkg, mvt_matrix and mvt_row.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata/s_tuser) carries one item per beat.
//   s_tuser selects the operation: a write beat stores element_value at
//   (row, column) and produces no output; a transform beat carries a vector.
//   Master channel (m_tvalid/m_tready/m_tdata/m_tuser) returns one beat per
//   transform: the four row dot products, each floor-shifted by FRAC_BITS and
//   clamped to 32 bits, with m_tuser set if any of them was clamped.
// Timing:
//   Four register stages (input, products, pair sums, result); a transform
//   passes them in that order to the master side. One beat per cycle sustained
//   while m_tready is high; the 32x32 products set the stage boundary.
//   A write takes effect at its accept edge and is seen by every later transform.
// Reset clears the matrix to zeros and empties the pipeline.
// Stall: with m_tready low the result beat holds; earlier stages keep filling,
// and s_tready drops only once every stage holds a transform.
`default_nettype none

module matrix4_vector_transform
  import mvt_pkg::*;
#(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // s_tdata: row[1:0], column[3:2], element_value[35:4], vec_x[67:36],
  //          vec_y[99:68], vec_z[131:100], vec_w[163:132], zero pad [167:164]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: operation[0]
  input  wire logic                   s_tuser,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // m_tdata: out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // m_tuser: saturated[0]
  output logic                        m_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready
);

  logic       acc;
  logic       go_in;
  logic       v_in;
  logic       v_mul;
  logic       v_pair;
  stage_ctl_t ctl;
  q16_t       vec_q [VEC_LEN];
  q16_t       elem  [DIM][DIM];
  q16_t       res   [VEC_LEN];
  logic       rsat  [VEC_LEN];

  assign ctl.en_out  = !m_tvalid || m_tready;
  assign ctl.en_pair = !v_pair || ctl.en_out;
  assign ctl.en_mul  = !v_mul || ctl.en_pair;
  assign go_in       = !v_in || ctl.en_mul;
  assign s_tready    = go_in;
  assign acc         = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in     <= 1'b0;
      v_mul    <= 1'b0;
      v_pair   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (go_in) begin
        v_in <= acc && s_tuser == OP_TRANSFORM;
      end
      if (ctl.en_mul) begin
        v_mul <= v_in;
      end
      if (ctl.en_pair) begin
        v_pair <= v_mul;
      end
      if (ctl.en_out) begin
        m_tvalid <= v_pair;
      end
    end
  end

  for (genvar i = 0; i < VEC_LEN; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (go_in) begin
        vec_q[i] <= s_tdata[VEC_LSB + i*ELEM_W +: ELEM_W];
      end
    end
  end

  mvt_matrix #(
    .DIM (DIM)
  ) u_matrix (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (acc && s_tuser == OP_WRITE),
    .wr_row  (s_tdata[ROW_LSB +: IDX_W]),
    .wr_col  (s_tdata[COL_LSB +: IDX_W]),
    .wr_data (s_tdata[ELEM_LSB +: ELEM_W]),
    .elem    (elem)
  );

  for (genvar r = 0; r < VEC_LEN; r++) begin : g_row
    if (r < DIM) begin : g_live
      mvt_row #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
      ) u_row (
        .clk    (clk),
        .ctl    (ctl),
        .coef   (elem[r]),
        .vec    (vec_q),
        .result (res[r]),
        .sat    (rsat[r])
      );
    end else begin : g_off
      // rows beyond DIM read as zero
      assign res[r]  = '0;
      assign rsat[r] = 1'b0;
    end
    assign m_tdata[r*ELEM_W +: ELEM_W] = res[r];
  end

  always_comb begin
    m_tuser = 1'b0;
    for (int r = 0; r < VEC_LEN; r++) begin
      m_tuser = m_tuser | rsat[r];
    end
  end

`ifndef SYNTHESIS
  // input stalls only when every stage is occupied and the output is blocked
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v_in && v_mul && v_pair && m_tvalid && !m_tready))
    else $error("s_tready low with room in the pipeline");

  a_transform_enters: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tuser == OP_TRANSFORM) |=> v_in)
    else $error("accepted transform beat lost at input register");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tuser == OP_WRITE) |=> !v_in)
    else $error("write beat entered the transform pipeline");

  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (res[0] == q16_t'(32'h7FFF_FFFF) || res[0] == q16_t'(32'h8000_0000) ||
       res[1] == q16_t'(32'h7FFF_FFFF) || res[1] == q16_t'(32'h8000_0000) ||
       res[2] == q16_t'(32'h7FFF_FFFF) || res[2] == q16_t'(32'h8000_0000) ||
       res[3] == q16_t'(32'h7FFF_FFFF) || res[3] == q16_t'(32'h8000_0000)))
    else $error("saturated flag without a clamped output");
`endif

endmodule

`default_nettype wire
